[sv/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, idle during reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check, also evaluated while reset is asserted
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/llme_pkg.sv]
package llme_pkg;

    // label and stream widths, default item count and minimum count
    localparam int LABEL_W       = 7;
    localparam int FUNC_W        = 2;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 8;
    localparam int MAX_ITEMS_DEF = 64;
    localparam int COUNT_MIN     = 2;

    // command codes
    localparam logic [FUNC_W-1:0] FN_INIT   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_BEFORE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_AFTER  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_DUMP   = 2'd3;

    typedef logic [LABEL_W-1:0] label_t;

endpackage

[sv/linked_list_move_engine_top.sv]
// channel   dir  tdata fields (lsb first)                 tlast       tuser
// s_axis    in   func[1:0] item_a[8:2] item_b[15:9]         -           -
// m_axis    out  item_label[6:0], zero pad bit 7            last label  -
// cfg       in   cfg_wdata = item_count (saturated 2..max)  -           -
//
// init completes on acceptance; a move reads A, then B, then issues unlink, place and
// relink writes on the single write port of each link memory; a bad label drops it
// a move already in front stops after reading A, one already behind after reading B
// a dump walks from the head, each successor read feeding the next address
// reset (or a count write, or init) clears the per-entry valid bits; an entry
// not yet written reads as its identity link, so no clearing pass is needed
// a stalled m_tready holds the dump walk; s_tready is high only between commands
`include "assert_macros.svh"

module linked_list_move_engine_top #(
    parameter int MAX_ITEMS = llme_pkg::MAX_ITEMS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // slave side: func, item_a, item_b
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [llme_pkg::S_TDATA_W-1:0] s_tdata,   // func[1:0] item_a[8:2] item_b[15:9]
    // master side: dump labels
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [llme_pkg::M_TDATA_W-1:0] m_tdata,   // item_label[6:0], pad[7]
    output logic                           m_tlast,
    // item_count register
    input  logic                           cfg_we,
    input  logic [llme_pkg::LABEL_W-1:0]   cfg_wdata
);
    import llme_pkg::*;

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RDA  = 3'd1;
    localparam logic [2:0] ST_RDB  = 3'd2;
    localparam logic [2:0] ST_W1   = 3'd3;
    localparam logic [2:0] ST_W2   = 3'd4;
    localparam logic [2:0] ST_DOUT = 3'd5;

    localparam label_t ONE     = LABEL_W'(1);
    localparam label_t MAX_LBL = LABEL_W'(MAX_ITEMS);
    localparam label_t MIN_LBL = LABEL_W'(COUNT_MIN);

    // label to memory index
    function automatic logic [IDX_W-1:0] slot_of(input label_t lbl);
        label_t t;
        t = lbl - ONE;
        return t[IDX_W-1:0];
    endfunction

    // link memories
    label_t next_mem [MAX_ITEMS];
    label_t prev_mem [MAX_ITEMS];

    // control and payload registers
    logic [2:0]           state_reg, state_next;
    logic                 before_reg, before_next;
    label_t               a_reg, a_next;
    label_t               b_reg, b_next;
    label_t               p_reg, p_next;
    label_t               n_reg, n_next;
    label_t               m_reg, m_next;
    label_t               cur_reg, cur_next;
    label_t               cnt_reg, cnt_next;
    label_t               head_reg, head_next;
    label_t               count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    label_t               out_label_reg, out_label_next;
    logic                 out_last_reg, out_last_next;
    logic [MAX_ITEMS-1:0] next_vld_reg, next_vld_next;
    logic [MAX_ITEMS-1:0] prev_vld_reg, prev_vld_next;

    // read side
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    label_t           next_q_reg, prev_q_reg;
    logic             next_qv_reg, prev_qv_reg;
    logic [IDX_W-1:0] q_idx_reg;
    label_t           q_label;
    label_t           next_rd, prev_rd;

    // write side
    logic             nx_we, pv_we;
    logic [IDX_W-1:0] nx_wa, pv_wa;
    label_t           nx_wd, pv_wd;

    // decode of the incoming transaction
    logic [FUNC_W-1:0] in_func;
    label_t            in_a, in_b;
    logic              in_accept;
    logic              move_ok;
    logic              clear_links;
    logic              load_out;
    logic              dump_last;
    label_t            cfg_sat;

    assign in_func   = s_tdata[FUNC_W-1:0];
    assign in_a      = s_tdata[FUNC_W +: LABEL_W];
    assign in_b      = s_tdata[FUNC_W+LABEL_W +: LABEL_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign move_ok = (in_a != '0) && (in_b != '0) && (in_a <= count_reg)
                     && (in_b <= count_reg) && (in_a != in_b);

    assign cfg_sat = (cfg_wdata < MIN_LBL) ? MIN_LBL :
                     (cfg_wdata > MAX_LBL) ? MAX_LBL : cfg_wdata;

    // unwritten entries read as the identity order for the current count
    assign q_label = LABEL_W'(q_idx_reg) + ONE;
    assign next_rd = next_qv_reg ? next_q_reg :
                     ((q_label == count_reg) ? '0 : q_label + ONE);
    assign prev_rd = prev_qv_reg ? prev_q_reg : q_label - ONE;

    assign dump_last = ((cnt_reg + ONE) == count_reg) || (next_rd == '0);

    always_comb
    begin
        state_next     = state_reg;
        before_next    = before_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        out_label_next = out_label_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        rd_en          = 1'b0;
        rd_idx         = '0;
        nx_we          = 1'b0;
        nx_wa          = '0;
        nx_wd          = '0;
        pv_we          = 1'b0;
        pv_wa          = '0;
        pv_wd          = '0;
        clear_links    = 1'b0;
        load_out       = 1'b0;

        if (cfg_we)
        begin
            count_next  = cfg_sat;
            clear_links = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_func)
                        FN_INIT:
                        begin
                            clear_links = 1'b1;
                        end
                        FN_DUMP:
                        begin
                            rd_en      = 1'b1;
                            rd_idx     = slot_of(head_reg);
                            cur_next   = head_reg;
                            cnt_next   = '0;
                            state_next = ST_DOUT;
                        end
                        default:
                        begin
                            if (move_ok)
                            begin
                                rd_en       = 1'b1;
                                rd_idx      = slot_of(in_a);
                                a_next      = in_a;
                                b_next      = in_b;
                                before_next = (in_func == FN_BEFORE);
                                state_next  = ST_RDA;
                            end
                        end
                    endcase
                end
            end
            ST_RDA:
            begin
                // links of A arrive, fetch links of B
                p_next = prev_rd;
                n_next = next_rd;
                if (before_reg && (next_rd == b_reg))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_idx     = slot_of(b_reg);
                    state_next = ST_RDB;
                end
            end
            ST_RDB:
            begin
                m_next = before_reg ? prev_rd : next_rd;
                if (!before_reg && (next_rd == a_reg))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    // unlink A
                    nx_we      = (p_reg != '0);
                    nx_wa      = slot_of(p_reg);
                    nx_wd      = n_reg;
                    pv_we      = (n_reg != '0);
                    pv_wa      = slot_of(n_reg);
                    pv_wd      = p_reg;
                    state_next = ST_W1;
                end
            end
            ST_W1:
            begin
                // new links of A
                nx_we      = 1'b1;
                nx_wa      = slot_of(a_reg);
                nx_wd      = before_reg ? b_reg : m_reg;
                pv_we      = 1'b1;
                pv_wa      = slot_of(a_reg);
                pv_wd      = before_reg ? m_reg : b_reg;
                state_next = ST_W2;
            end
            ST_W2:
            begin
                // neighbors point back at A
                if (before_reg)
                begin
                    nx_we = (m_reg != '0);
                    nx_wa = slot_of(m_reg);
                    pv_we = 1'b1;
                    pv_wa = slot_of(b_reg);
                end
                else
                begin
                    nx_we = 1'b1;
                    nx_wa = slot_of(b_reg);
                    pv_we = (m_reg != '0);
                    pv_wa = slot_of(m_reg);
                end
                nx_wd = a_reg;
                pv_wd = a_reg;
                if (p_reg == '0)
                begin
                    head_next = n_reg;
                end
                if (before_reg && (m_reg == '0))
                begin
                    head_next = a_reg;
                end
                state_next = ST_IDLE;
            end
            ST_DOUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    out_label_next = cur_reg;
                    out_last_next  = dump_last;
                    if (dump_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_idx   = slot_of(next_rd);
                        cur_next = next_rd;
                        cnt_next = cnt_reg + ONE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        next_vld_next = next_vld_reg;
        prev_vld_next = prev_vld_reg;
        if (clear_links)
        begin
            next_vld_next = '0;
            prev_vld_next = '0;
            head_next     = ONE;
        end
        else
        begin
            if (nx_we)
            begin
                next_vld_next[nx_wa] = 1'b1;
            end
            if (pv_we)
            begin
                prev_vld_next[pv_wa] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= ONE;
            count_reg     <= MAX_LBL;
            out_valid_reg <= 1'b0;
            next_vld_reg  <= '0;
            prev_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            next_vld_reg  <= next_vld_next;
            prev_vld_reg  <= prev_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        before_reg    <= before_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        p_reg         <= p_next;
        n_reg         <= n_next;
        m_reg         <= m_next;
        cur_reg       <= cur_next;
        cnt_reg       <= cnt_next;
        out_label_reg <= out_label_next;
        out_last_reg  <= out_last_next;
    end

    // link memories, one read and one write port each
    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (pv_we)
        begin
            prev_mem[pv_wa] <= pv_wd;
        end
        if (rd_en)
        begin
            next_q_reg  <= next_mem[rd_idx];
            prev_q_reg  <= prev_mem[rd_idx];
            next_qv_reg <= next_vld_reg[rd_idx];
            prev_qv_reg <= prev_vld_reg[rd_idx];
            q_idx_reg   <= rd_idx;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_label_reg);
    assign m_tlast  = out_last_reg;

    `ASSERT_ALWAYS(a_count_range, (!rst_n) || ((count_reg >= MIN_LBL) && (count_reg <= MAX_LBL)), "item count out of range")
    `ASSERT_CLK(a_head_valid, (head_reg != '0) && (head_reg <= count_reg), "head label invalid")
    `ASSERT_CLK(a_idle_no_write, (state_reg == ST_IDLE) |-> (!nx_we && !pv_we), "link write while idle")
    `ASSERT_CLK(a_load_free, load_out |-> (!out_valid_reg || m_tready), "dump label overwrites pending transaction")
    `ASSERT_CLK(a_last_ends, (load_out && dump_last) |=> (state_reg == ST_IDLE), "dump continues past last label")

endmodule
